### hdl/shcf_pkg.sv
package shcf_pkg;

  localparam int DATA_W     = 8;
  localparam int PAT_BYTES_W = 64;
  localparam int PLEN_W     = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [PAT_BYTES_W-1:0] PATTERN_BYTES_RST  = '0;
  localparam logic [PLEN_W-1:0]      PATTERN_LENGTH_RST = 4'd1;
  localparam logic [DATA_W-1:0]      END_CHARACTER_RST  = 8'd58;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES  = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1,
    CFG_END_CHARACTER  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_SEEK,
    PH_REMOVED,
    PH_GIVEN_UP
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_DRAIN,
    ST_FLUSH_WIN,
    ST_MEM_RD,
    ST_MEM_EMIT,
    ST_EMIT_B,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_byte;
    logic              has_byte;
    logic              run_last;
    logic              string_done;
    logic              header_found;
  } out_item_t;

endpackage

### hdl/shcf_if.sv
interface shcf_feed_if;
  import shcf_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              string_end;

  modport source (output valid, data_byte, string_end, input ready);
  modport sink   (input valid, data_byte, string_end, output ready);
endinterface

interface shcf_result_if;
  import shcf_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] out_byte;
  logic              has_byte;
  logic              run_last;
  logic              string_done;
  logic              header_found;

  modport source (output valid, out_byte, has_byte, run_last, string_done, header_found,
                  input ready);
  modport sink   (input valid, out_byte, has_byte, run_last, string_done, header_found,
                  output ready);
endinterface

interface shcf_cfg_if;
  import shcf_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [PAT_BYTES_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

### hdl/stream_header_cut_filter_core.sv
// Header cut filter. Takes a string one byte per word, last byte flagged, and removes the
// first occurrence of the configured pattern together with the byte after it and everything
// up to and including the next end character, unless the string ends or the buffer fills
// first; other bytes pass through in order. Bytes of a partial match sit in a PATTERN_MAX-byte
// shift window, the header tail in a HOLD_DEPTH-entry buffer RAM. The window is checked
// against the pattern prefix combinationally, and the window drain and the single RAM
// read port are reused under a small sequencer; the input is not ready while a word is
// worked on. A header byte that is only stored is accepted and closed; a search byte or a
// passed byte is accepted, processed and closed. Bytes released from the window go out one
// at a time, a string end or an overflow adds a window flush, each byte released from the
// buffer RAM takes a registered read and an emit, and a full output stall holds the
// sequencer. The result has one output register, so the next byte can be taken while the
// last result waits. Configuration writes are taken in any cycle and act at once.
module stream_header_cut_filter_core #(
  parameter int PATTERN_MAX = 8,
  parameter int HOLD_DEPTH  = 32
) (
  input logic          clk,
  input logic          rst,
  shcf_feed_if.sink    feed,
  shcf_result_if.source result,
  shcf_cfg_if.sink     cfg
);
  import shcf_pkg::*;

  localparam int WCW = $clog2(PATTERN_MAX + 1);
  localparam int CW  = $clog2(HOLD_DEPTH + 1);
  localparam int AW  = $clog2(HOLD_DEPTH);

  // configuration registers
  logic [PAT_BYTES_W-1:0] pattern_bytes;
  logic [PLEN_W-1:0]      pattern_length;
  logic [DATA_W-1:0]      end_character;

  // control state
  state_t           state, state_next;
  phase_t           phase;
  logic [WCW-1:0]   win_count;
  logic [CW-1:0]    mem_count;
  logic [AW-1:0]    rd_idx;
  logic             extra;
  logic             emit_b;
  logic             out_v;
  logic             pend_v;

  // payload
  logic [DATA_W-1:0] win [PATTERN_MAX];
  logic [DATA_W-1:0] mem [HOLD_DEPTH];
  logic [DATA_W-1:0] mem_rdata;
  logic [DATA_W-1:0] cur_byte;
  logic              cur_last;
  logic [DATA_W-1:0] pend_byte;
  out_item_t         out_data;

  // combinational
  logic              accept;
  logic [WCW-1:0]    plen;
  logic              prefix_ok;
  logic [CW:0]       hold_sum;
  logic              end_hit;
  logic              over;
  logic              out_free;
  logic              can_push;
  logic              push;
  logic [DATA_W-1:0] push_byte;
  logic              pop_win;
  logic              srch_done;
  logic              mem_step;
  logic              mem_last;
  logic              fin_fire;
  logic              found;
  logic              out_load;
  out_item_t         out_load_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= PATTERN_BYTES_RST;
      pattern_length <= PATTERN_LENGTH_RST;
      end_character  <= END_CHARACTER_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_PATTERN_BYTES:  pattern_bytes  <= cfg.wdata;
        CFG_PATTERN_LENGTH: pattern_length <= cfg.wdata[PLEN_W-1:0];
        CFG_END_CHARACTER:  end_character  <= cfg.wdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // effective pattern length, clamped to 1..PATTERN_MAX
  always_comb begin
    if (pattern_length == '0) begin
      plen = WCW'(1);
    end else if (pattern_length > PLEN_W'(PATTERN_MAX)) begin
      plen = WCW'(PATTERN_MAX);
    end else begin
      plen = WCW'(pattern_length);
    end
  end

  // window vs pattern prefix, one byte compare per window slot
  always_comb begin
    prefix_ok = (win_count <= plen);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (WCW'(i) < win_count && win[i] != pattern_bytes[8*i +: 8]) begin
        prefix_ok = 1'b0;
      end
    end
  end

  assign hold_sum = (CW+1)'(win_count) + (CW+1)'(mem_count);
  assign end_hit  = extra && (feed.data_byte == end_character);
  assign over     = (hold_sum >= (CW+1)'(HOLD_DEPTH));
  assign accept   = feed.valid && feed.ready;
  assign out_free = !out_v || result.ready;
  assign can_push = !pend_v || out_free;
  assign mem_last = ((CW'(rd_idx) + CW'(1)) == mem_count);
  assign found    = cur_last && (phase == PH_REMOVED);

  // sequencer outputs
  always_comb begin
    feed.ready = (state == ST_IDLE);
    push       = 1'b0;
    push_byte  = cur_byte;
    pop_win    = 1'b0;
    srch_done  = 1'b0;
    mem_step   = 1'b0;
    fin_fire   = 1'b0;
    unique case (state)
      ST_IDLE: ;
      ST_SRCH_DRAIN: begin
        if (win_count != '0 && !prefix_ok) begin
          push      = can_push;
          push_byte = win[0];
          pop_win   = can_push;
        end else begin
          srch_done = 1'b1;
        end
      end
      ST_FLUSH_WIN: begin
        if (win_count != '0) begin
          push      = can_push;
          push_byte = win[0];
          pop_win   = can_push;
        end
      end
      ST_MEM_RD: ;
      ST_MEM_EMIT: begin
        push      = can_push;
        push_byte = mem_rdata;
        mem_step  = can_push;
      end
      ST_EMIT_B: begin
        push      = can_push;
        push_byte = cur_byte;
      end
      ST_FINISH: begin
        fin_fire = out_free || (!pend_v && !cur_last);
      end
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (phase)
            PH_SEARCH: state_next = ST_SRCH_DRAIN;
            PH_SEEK: begin
              priority if (end_hit) state_next = ST_FINISH;
              else if (over)        state_next = ST_FLUSH_WIN;
              else if (feed.string_end) state_next = ST_FLUSH_WIN;
              else                  state_next = ST_FINISH;
            end
            default: state_next = ST_EMIT_B;
          endcase
        end
      end
      ST_SRCH_DRAIN: begin
        if (srch_done) state_next = cur_last ? ST_FLUSH_WIN : ST_FINISH;
      end
      ST_FLUSH_WIN: begin
        if (win_count == '0) begin
          priority if (mem_count != '0) state_next = ST_MEM_RD;
          else if (emit_b)              state_next = ST_EMIT_B;
          else                          state_next = ST_FINISH;
        end
      end
      ST_MEM_RD: state_next = ST_MEM_EMIT;
      ST_MEM_EMIT: begin
        if (mem_step) begin
          priority if (!mem_last) state_next = ST_MEM_RD;
          else if (emit_b)        state_next = ST_EMIT_B;
          else                    state_next = ST_FINISH;
        end
      end
      ST_EMIT_B: begin
        if (push) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (fin_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // pending word goes out with run_last clear when a newer one follows,
  // and with the closing flags when the input word is done
  always_comb begin
    out_load      = 1'b0;
    out_load_data = '0;
    if (push && pend_v) begin
      out_load               = 1'b1;
      out_load_data.out_byte = pend_byte;
      out_load_data.has_byte = 1'b1;
    end else if (fin_fire && pend_v) begin
      out_load                   = 1'b1;
      out_load_data.out_byte     = pend_byte;
      out_load_data.has_byte     = 1'b1;
      out_load_data.run_last     = 1'b1;
      out_load_data.string_done  = cur_last;
      out_load_data.header_found = found;
    end else if (fin_fire && cur_last) begin
      out_load                   = 1'b1;
      out_load_data.run_last     = 1'b1;
      out_load_data.string_done  = 1'b1;
      out_load_data.header_found = found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_SEARCH;
      win_count <= '0;
      mem_count <= '0;
      rd_idx    <= '0;
      extra     <= 1'b0;
      emit_b    <= 1'b0;
      out_v     <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      state <= state_next;

      if (out_load) out_v <= 1'b1;
      else if (result.ready) out_v <= 1'b0;
      if (push) pend_v <= 1'b1;
      else if (fin_fire) pend_v <= 1'b0;

      if (accept) begin
        rd_idx <= '0;
        emit_b <= 1'b0;
        unique case (phase)
          PH_SEARCH: win_count <= win_count + WCW'(1);
          PH_SEEK: begin
            priority if (end_hit) begin
              win_count <= '0;
              mem_count <= '0;
              phase     <= PH_REMOVED;
            end else if (over) begin
              phase  <= PH_GIVEN_UP;
              emit_b <= 1'b1;
            end else begin
              mem_count <= mem_count + CW'(1);
              extra     <= 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (srch_done && win_count == plen) begin
        phase <= PH_SEEK;
        extra <= 1'b0;
      end

      if (pop_win) win_count <= win_count - WCW'(1);

      if (mem_step) begin
        if (mem_last) mem_count <= '0;
        else rd_idx <= rd_idx + AW'(1);
      end

      if (fin_fire && cur_last) begin
        phase     <= PH_SEARCH;
        win_count <= '0;
        mem_count <= '0;
        extra     <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_byte <= feed.data_byte;
      cur_last <= feed.string_end;
    end
    if (accept && phase == PH_SEARCH) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        if (win_count == WCW'(i)) win[i] <= feed.data_byte;
      end
    end else if (pop_win) begin
      for (int i = 0; i < PATTERN_MAX - 1; i++) begin
        win[i] <= win[i+1];
      end
    end
    if (push) pend_byte <= push_byte;
    if (out_load) out_data <= out_load_data;
  end

  // header tail buffer
  always_ff @(posedge clk) begin
    if (accept && phase == PH_SEEK && !end_hit && !over) begin
      mem[mem_count[AW-1:0]] <= feed.data_byte;
    end
    mem_rdata <= mem[rd_idx];
  end

  assign result.valid        = out_v;
  assign result.out_byte     = out_data.out_byte;
  assign result.has_byte     = out_data.has_byte;
  assign result.run_last     = out_data.run_last;
  assign result.string_done  = out_data.string_done;
  assign result.header_found = out_data.header_found;

endmodule

### hdl/shcf_checker.sv
module shcf_checker (
  input logic       clk,
  input logic       rst,
  input logic       r_valid,
  input logic       r_ready,
  input logic [7:0] r_out_byte,
  input logic       r_has_byte,
  input logic       r_run_last,
  input logic       r_string_done,
  input logic       r_header_found
);

  // an empty word only closes a string
  a_empty_is_done: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_has_byte |-> r_string_done && r_out_byte == 8'h00)
    else $error("empty result word outside string end");

  a_found_needs_done: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_header_found |-> r_string_done)
    else $error("header_found without string_done");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_string_done |-> r_run_last)
    else $error("string_done on a word that is not the last of its byte");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid)
    else $error("result word dropped while stalled");

endmodule

bind stream_header_cut_filter_core shcf_checker u_shcf_checker (
  .clk            (clk),
  .rst            (rst),
  .r_valid        (result.valid),
  .r_ready        (result.ready),
  .r_out_byte     (result.out_byte),
  .r_has_byte     (result.has_byte),
  .r_run_last     (result.run_last),
  .r_string_done  (result.string_done),
  .r_header_found (result.header_found)
);

### test/stream_header_cut_filter_core_tb.sv
`timescale 1ns / 100ps

module stream_header_cut_filter_core_tb;
  import shcf_pkg::*;

  localparam int PATTERN_MAX = 8;
  localparam int HOLD_DEPTH = 32;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;

  localparam logic [DATA_W-1:0] CH_A = 8'h61;
  localparam logic [DATA_W-1:0] CH_B = 8'h62;
  localparam logic [DATA_W-1:0] CH_C = 8'h63;
  localparam logic [DATA_W-1:0] CH_Q = 8'h71;
  localparam logic [DATA_W-1:0] CH_X = 8'h78;
  localparam logic [DATA_W-1:0] CH_Z = 8'h7A;
  localparam logic [DATA_W-1:0] CH_K = 8'h6B;
  localparam logic [DATA_W-1:0] CH_COLON = 8'h3A;
  localparam logic [PAT_BYTES_W-1:0] PAT_AAB = 64'h0000_0000_0062_6161;

  logic clk;
  logic rst;

  shcf_feed_if feed();
  shcf_result_if result();
  shcf_cfg_if cfg();

  // predictor copy of registers and filter state
  logic [PAT_BYTES_W-1:0] pat_word = PATTERN_BYTES_RST;
  logic [PLEN_W-1:0] pat_len = PATTERN_LENGTH_RST;
  logic [DATA_W-1:0] end_char = END_CHARACTER_RST;
  phase_t cut_phase = PH_SEARCH;
  logic extra_seen = 1'b0;
  logic [DATA_W-1:0] held_bytes[$];
  out_item_t due_words[$];

  int bad_words = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  // sender burst state
  int burst_left = 0;
  bit gaps_on = 1'b1;

  // receiver stall pattern and long hold-off request
  logic [15:0] ready_pat = 16'hFFFF;
  bit hold_req = 1'b0;
  int holdoff_left = 0;

  stream_header_cut_filter_core #(
    .PATTERN_MAX(PATTERN_MAX),
    .HOLD_DEPTH(HOLD_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .feed(feed),
    .result(result),
    .cfg(cfg)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    if (hold_req) begin
      holdoff_left = HOLDOFF_CYCLES;
      hold_req = 1'b0;
    end
    if (holdoff_left > 0) begin
      result.ready <= 1'b0;
      holdoff_left--;
    end else begin
      result.ready <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[15:1]};
    end
  end

  function automatic void log_bad(string why, out_item_t want, out_item_t got);
    bad_words++;
    if (bad_words <= 10) begin
      $display("%0t %s: expected byte %h has %b last %b done %b found %b", $time, why,
               want.out_byte, want.has_byte, want.run_last, want.string_done,
               want.header_found);
      $display("    got byte %h has %b last %b done %b found %b", got.out_byte,
               got.has_byte, got.run_last, got.string_done, got.header_found);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst && result.valid === 1'b1 && result.ready) begin
      got.out_byte = result.out_byte;
      got.has_byte = result.has_byte;
      got.run_last = result.run_last;
      got.string_done = result.string_done;
      got.header_found = result.header_found;
      if (due_words.size() == 0) begin
        log_bad("unexpected word", '0, got);
      end else begin
        want = due_words.pop_front();
        if (got !== want) log_bad("wrong word", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (feed.valid && feed.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles without a handshake", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int eff_len();
    int n;
    n = pat_len;
    if (n == 0) n = 1;
    if (n > PATTERN_MAX) n = PATTERN_MAX;
    return n;
  endfunction

  function automatic logic [DATA_W-1:0] pat_char(int i);
    return pat_word[8*i +: 8];
  endfunction

  function automatic out_item_t make_word(logic [DATA_W-1:0] b, logic has);
    out_item_t w;
    w = '0;
    w.out_byte = b;
    w.has_byte = has;
    return w;
  endfunction

  function automatic bit held_is_prefix(int plen);
    if (held_bytes.size() > plen) return 1'b0;
    foreach (held_bytes[i])
      if (held_bytes[i] != pat_char(i)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void release_held(ref out_item_t words[$]);
    while (held_bytes.size() > 0) words.push_back(make_word(held_bytes.pop_front(), 1'b1));
  endfunction

  // expected words caused by one accepted input byte
  function automatic void filter_byte(logic [DATA_W-1:0] b, logic last);
    out_item_t words[$];
    out_item_t w;
    int plen;
    logic found;
    plen = eff_len();
    case (cut_phase)
      PH_SEARCH: begin
        held_bytes.push_back(b);
        while (held_bytes.size() > 0 && !held_is_prefix(plen))
          words.push_back(make_word(held_bytes.pop_front(), 1'b1));
        if (held_bytes.size() == plen) begin
          cut_phase = PH_SEEK;
          extra_seen = 1'b0;
        end
      end
      PH_SEEK: begin
        // byte right after the pattern is never taken as the end character
        if (extra_seen && b == end_char) begin
          held_bytes.delete();
          cut_phase = PH_REMOVED;
        end else if (held_bytes.size() >= HOLD_DEPTH) begin
          release_held(words);
          words.push_back(make_word(b, 1'b1));
          cut_phase = PH_GIVEN_UP;
        end else begin
          held_bytes.push_back(b);
          extra_seen = 1'b1;
        end
      end
      default: words.push_back(make_word(b, 1'b1));
    endcase
    if (last) begin
      found = (cut_phase == PH_REMOVED);
      release_held(words);
      if (words.size() == 0) words.push_back(make_word('0, 1'b0));
      w = words[words.size()-1];
      w.string_done = 1'b1;
      w.header_found = found;
      words[words.size()-1] = w;
      cut_phase = PH_SEARCH;
      extra_seen = 1'b0;
    end
    if (words.size() > 0) begin
      w = words[words.size()-1];
      w.run_last = 1'b1;
      words[words.size()-1] = w;
    end
    foreach (words[i]) due_words.push_back(words[i]);
  endfunction

  function automatic logic [DATA_W-1:0] near_byte();
    if ($urandom_range(0, 1)) return pat_char($urandom_range(0, eff_len() - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [DATA_W-1:0] header_byte();
    logic [DATA_W-1:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == end_char) b = ~b;
    return b;
  endfunction

  task automatic send_word(input logic [DATA_W-1:0] b, input logic last);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (gaps_on) gap = $urandom_range(0, 6);
    end
    @(negedge clk);
    if (gap > 0) begin
      feed.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    feed.valid <= 1'b1;
    feed.data_byte <= b;
    feed.string_end <= last;
    do @(posedge clk); while (!feed.ready);
    filter_byte(b, last);
    items_sent++;
    burst_left--;
  endtask

  task automatic send_string(input logic [DATA_W-1:0] s[$]);
    for (int i = 0; i < s.size(); i++) send_word(s[i], i == s.size() - 1);
  endtask

  task automatic feed_idle();
    @(negedge clk) feed.valid <= 1'b0;
    burst_left = 0;
  endtask

  // stop sending until every expected word is in, then let the core settle
  task automatic wait_drained();
    feed_idle();
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [PAT_BYTES_W-1:0] v);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= v;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      CFG_PATTERN_BYTES: pat_word = v;
      CFG_PATTERN_LENGTH: pat_len = v[PLEN_W-1:0];
      CFG_END_CHARACTER: end_char = v[DATA_W-1:0];
      default: ;
    endcase
    @(negedge clk) cfg.valid <= 1'b0;
  endtask

  // reset registers: single zero byte pattern, colon delimiter
  task automatic test_power_on_config();
    send_string({8'h00, CH_Q, CH_COLON, 8'hFF});
  endtask

  // overlapping prefix must re-match; delimiter right after the pattern is skipped
  task automatic test_rematch_cut();
    wait_drained();
    write_reg(CFG_PATTERN_BYTES, PAT_AAB);
    write_reg(CFG_PATTERN_LENGTH, 64'd3);
    write_reg(CFG_END_CHARACTER, 64'(CH_COLON));
    send_string({CH_A, CH_A, CH_A, CH_B, CH_COLON, CH_Z, CH_COLON, CH_K});
  endtask

  task automatic test_unfinished_header();
    send_string({CH_A, CH_A, CH_B, CH_X});
  endtask

  // string ends on the delimiter: nothing left, one empty word closes it
  task automatic test_bare_end();
    send_string({CH_A, CH_A, CH_B, CH_X, CH_COLON});
  endtask

  task automatic test_length_clamp();
    wait_drained();
    write_reg(CFG_PATTERN_LENGTH, 64'd0);
    send_string({CH_A, CH_B, CH_COLON});
    wait_drained();
    write_reg(CFG_PATTERN_LENGTH, 64'd15);
    send_word(CH_A, 1'b0);
    send_word(CH_A, 1'b0);
    // shorten the pattern while two bytes sit in the match window
    wait_drained();
    write_reg(CFG_PATTERN_LENGTH, 64'd1);
    send_word(CH_C, 1'b0);
    send_word(CH_X, 1'b1);
  endtask

  // fill the header buffer; receiver holds off so the core backs up
  task automatic test_hold_overflow();
    logic [DATA_W-1:0] s[$];
    wait_drained();
    write_reg(CFG_PATTERN_BYTES, {$urandom, $urandom});
    write_reg(CFG_PATTERN_LENGTH, 64'd2);
    write_reg(CFG_END_CHARACTER, 64'($urandom_range(0, 255)));
    gaps_on = 1'b0;
    ready_pat = 16'hFFFF;
    s = {pat_char(0), pat_char(1), 8'($urandom_range(0, 255))};
    repeat (HOLD_DEPTH - 3) s.push_back(header_byte());
    s.push_back(header_byte());
    repeat (2) s.push_back(8'($urandom_range(0, 255)));
    hold_req = 1'b1;
    send_string(s);
    wait_drained();
    // buffer exactly full, then the delimiter still closes the header
    s = {pat_char(0), pat_char(1), 8'($urandom_range(0, 255))};
    repeat (HOLD_DEPTH - 3) s.push_back(header_byte());
    s.push_back(end_char);
    send_string(s);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_strings();
    logic [DATA_W-1:0] s[$];
    logic [PAT_BYTES_W-1:0] pv;
    int kind;
    int plen;
    int goal;
    for (int setting = 0; setting < 4; setting++) begin
      wait_drained();
      case (setting)
        0: begin
          write_reg(CFG_PATTERN_BYTES, '0);
          write_reg(CFG_PATTERN_LENGTH, 64'd1);
          write_reg(CFG_END_CHARACTER, 64'($urandom_range(0, 255)));
        end
        1: begin
          write_reg(CFG_PATTERN_BYTES, {$urandom, $urandom});
          write_reg(CFG_PATTERN_LENGTH, 64'd8);
          write_reg(CFG_END_CHARACTER, 64'h00);
        end
        2: begin
          write_reg(CFG_PATTERN_BYTES, '1);
          write_reg(CFG_PATTERN_LENGTH, 64'd15);
          write_reg(CFG_END_CHARACTER, 64'hFF);
        end
        default: begin
          // two-symbol alphabet gives plenty of overlapping partial matches
          for (int i = 0; i < PATTERN_MAX; i++)
            pv[8*i +: 8] = $urandom_range(0, 1) ? 8'h5A : 8'hA5;
          write_reg(CFG_PATTERN_BYTES, pv);
          write_reg(CFG_PATTERN_LENGTH, 64'($urandom_range(2, 4)));
          write_reg(CFG_END_CHARACTER, 64'(CH_COLON));
        end
      endcase
      gaps_on = (setting != 2);
      ready_pat = (setting == 2) ? 16'hFFFF : 16'($urandom) | 16'h0001;
      plen = eff_len();
      goal = items_sent + 1;
      while (items_sent < goal) begin
        s.delete();
        kind = $urandom_range(0, 9);
        repeat ($urandom_range(0, 4)) s.push_back(near_byte());
        if (kind < 7) begin
          for (int i = 0; i < plen; i++) s.push_back(pat_char(i));
          s.push_back(($urandom_range(0, 3) == 0) ? end_char : 8'($urandom_range(0, 255)));
          repeat ($urandom_range(0, 6)) s.push_back(header_byte());
          s.push_back(end_char);
          repeat ($urandom_range(0, 3)) s.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 9) begin
          // broken: cut inside the pattern or inside the header
          for (int i = 0; i < $urandom_range(1, plen); i++) s.push_back(pat_char(i));
          if ($urandom_range(0, 1))
            repeat ($urandom_range(1, 4)) s.push_back(header_byte());
        end else begin
          repeat ($urandom_range(1, 8)) s.push_back(8'($urandom_range(0, 255)));
        end
        if (s.size() == 0) s.push_back(8'($urandom_range(0, 255)));
        send_string(s);
        if ($urandom_range(0, 5) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    feed.valid = 1'b0;
    feed.data_byte = '0;
    feed.string_end = 1'b0;
    result.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_PATTERN_BYTES;
    cfg.wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_power_on_config();
    test_rematch_cut();
    test_unfinished_header();
    test_bare_end();
    test_length_clamp();
    test_hold_overflow();
    test_random_strings();

    feed_idle();
    while (due_words.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (bad_words == 0 && due_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
